### sv/ecpl_pkg.sv
// ----------------------------------------------------------------------------
// ecpl_pkg
// shared constants, codes and types of the empty-call paren locator
// ----------------------------------------------------------------------------
package ecpl_pkg;

   // size limits
   localparam int unsigned MaxScriptLen = 65536;
   localparam int unsigned MaxNestDepth = 255;
   localparam int unsigned PosWidth     = $clog2(MaxScriptLen + 1);
   localparam int unsigned DepthWidth   = $clog2(MaxNestDepth + 1);

   // fixed field widths
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned IndexWidth  = 16;
   localparam int unsigned LengthWidth = 18;
   localparam int unsigned StatusWidth = 3;

   // lexer modes
   localparam logic [2:0] ModeNormal    = 3'd0;
   localparam logic [2:0] ModePendSlash = 3'd1;
   localparam logic [2:0] ModePendC2    = 3'd2;
   localparam logic [2:0] ModeStr       = 3'd3;
   localparam logic [2:0] ModeStrEsc    = 3'd4;
   localparam logic [2:0] ModeAngle     = 3'd5;
   localparam logic [2:0] ModeAngleC2   = 3'd6;
   localparam logic [2:0] ModeLine      = 3'd7;

   // scan status codes
   localparam logic [StatusWidth-1:0] StatusOk         = 3'd0;
   localparam logic [StatusWidth-1:0] StatusNoParen    = 3'd1;
   localparam logic [StatusWidth-1:0] StatusUnbalanced = 3'd2;
   localparam logic [StatusWidth-1:0] StatusNotEmpty   = 3'd3;
   localparam logic [StatusWidth-1:0] StatusTooLong    = 3'd4;
   localparam logic [StatusWidth-1:0] StatusDepth      = 3'd5;

   // byte codes
   localparam logic [ByteWidth-1:0] ByteQuote     = 8'h22;
   localparam logic [ByteWidth-1:0] ByteBackslash = 8'h5C;
   localparam logic [ByteWidth-1:0] ByteOpen      = 8'h28;
   localparam logic [ByteWidth-1:0] ByteClose     = 8'h29;
   localparam logic [ByteWidth-1:0] ByteSlash     = 8'h2F;
   localparam logic [ByteWidth-1:0] ByteCr        = 8'h0D;
   localparam logic [ByteWidth-1:0] ByteLf        = 8'h0A;
   localparam logic [ByteWidth-1:0] ByteTab       = 8'h09;
   localparam logic [ByteWidth-1:0] ByteSpace     = 8'h20;
   localparam logic [ByteWidth-1:0] ByteLead      = 8'hC2;
   localparam logic [ByteWidth-1:0] ByteGuilOpen  = 8'hAB;
   localparam logic [ByteWidth-1:0] ByteGuilClose = 8'hBB;

   // bytes added around the argument: ( " " )
   localparam int unsigned WrapBytes = 4;

   typedef struct packed {
      logic [2:0]            mode;
      logic                  in_parens;
      logic [DepthWidth-1:0] depth;
      logic [PosWidth-1:0]   position;
      logic [IndexWidth-1:0] open_index;
      logic [IndexWidth-1:0] close_index;
      logic                  only_ws;
      logic                  finished;
      logic                  err_long;
      logic                  err_depth;
   } scan_state_type;

   localparam scan_state_type ScanReset = '{
      mode:        ModeNormal,
      in_parens:   1'b0,
      depth:       '0,
      position:    '0,
      open_index:  '0,
      close_index: '0,
      only_ws:     1'b1,
      finished:    1'b0,
      err_long:    1'b0,
      err_depth:   1'b0
   };

endpackage

### sv/ecpl_lexer.sv
// ----------------------------------------------------------------------------
// ecpl_lexer
// next scan state for one script byte
// ----------------------------------------------------------------------------
module ecpl_lexer (
   input  ecpl_pkg::scan_state_type              cur_state,
   input  logic [ecpl_pkg::ByteWidth-1:0]        script_byte,
   output ecpl_pkg::scan_state_type              next_state
);

   ecpl_pkg::scan_state_type s;
   logic                     fresh;
   logic                     is_ws;

   always_comb begin
      s     = cur_state;
      fresh = 1'b0;
      is_ws = script_byte inside {ecpl_pkg::ByteSpace, ecpl_pkg::ByteTab,
                                  ecpl_pkg::ByteCr, ecpl_pkg::ByteLf};

      if (cur_state.position >= ecpl_pkg::PosWidth'(ecpl_pkg::MaxScriptLen)) begin
         s.err_long = 1'b1;
      end else begin
         if (!cur_state.err_long && !cur_state.err_depth && !cur_state.finished) begin
            case (cur_state.mode)
               ecpl_pkg::ModePendSlash: begin
                  if (script_byte == ecpl_pkg::ByteSlash) s.mode = ecpl_pkg::ModeLine;
                  else fresh = 1'b1;
               end
               ecpl_pkg::ModePendC2: begin
                  if (script_byte == ecpl_pkg::ByteGuilOpen) s.mode = ecpl_pkg::ModeAngle;
                  else fresh = 1'b1;
               end
               ecpl_pkg::ModeStr: begin
                  if (script_byte == ecpl_pkg::ByteBackslash) s.mode = ecpl_pkg::ModeStrEsc;
                  else if (script_byte == ecpl_pkg::ByteQuote) s.mode = ecpl_pkg::ModeNormal;
               end
               ecpl_pkg::ModeStrEsc: begin
                  s.mode = ecpl_pkg::ModeStr;
               end
               ecpl_pkg::ModeAngle: begin
                  if (script_byte == ecpl_pkg::ByteLead) s.mode = ecpl_pkg::ModeAngleC2;
               end
               ecpl_pkg::ModeAngleC2: begin
                  if (script_byte == ecpl_pkg::ByteGuilClose) s.mode = ecpl_pkg::ModeNormal;
                  else if (script_byte != ecpl_pkg::ByteLead) s.mode = ecpl_pkg::ModeAngle;
               end
               ecpl_pkg::ModeLine: begin
                  if (script_byte == ecpl_pkg::ByteLf || script_byte == ecpl_pkg::ByteCr) begin
                     s.mode = ecpl_pkg::ModeNormal;
                  end
               end
               default: begin
                  fresh = 1'b1;
               end
            endcase

            // byte scanned afresh in normal mode
            if (fresh) begin
               s.mode = ecpl_pkg::ModeNormal;
               if (script_byte == ecpl_pkg::ByteQuote) begin
                  s.mode = ecpl_pkg::ModeStr;
               end else if (script_byte == ecpl_pkg::ByteLead) begin
                  s.mode = ecpl_pkg::ModePendC2;
               end else if (script_byte == ecpl_pkg::ByteSlash) begin
                  s.mode = ecpl_pkg::ModePendSlash;
               end else if (script_byte == ecpl_pkg::ByteOpen) begin
                  if (!cur_state.in_parens) begin
                     s.in_parens  = 1'b1;
                     s.open_index = cur_state.position[ecpl_pkg::IndexWidth-1:0];
                     s.depth      = ecpl_pkg::DepthWidth'(1);
                     s.only_ws    = 1'b1;
                  end else if (cur_state.depth >=
                               ecpl_pkg::DepthWidth'(ecpl_pkg::MaxNestDepth)) begin
                     s.err_depth = 1'b1;
                  end else begin
                     s.depth = cur_state.depth + ecpl_pkg::DepthWidth'(1);
                  end
               end else if (script_byte == ecpl_pkg::ByteClose && cur_state.in_parens) begin
                  if (cur_state.depth <= ecpl_pkg::DepthWidth'(1)) begin
                     s.depth       = '0;
                     s.close_index = cur_state.position[ecpl_pkg::IndexWidth-1:0];
                     s.finished    = 1'b1;
                  end else begin
                     s.depth = cur_state.depth - ecpl_pkg::DepthWidth'(1);
                  end
               end
            end

            if (cur_state.in_parens && !s.finished && !is_ws) s.only_ws = 1'b0;
         end
         s.position = cur_state.position + ecpl_pkg::PosWidth'(1);
      end
      next_state = s;
   end

endmodule

### sv/ecpl_result.sv
// ----------------------------------------------------------------------------
// ecpl_result
// status and length formation with the result register
// ----------------------------------------------------------------------------
module ecpl_result (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   load,
   input  ecpl_pkg::scan_state_type               final_state,
   input  logic [ecpl_pkg::IndexWidth-1:0]        arg_length,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic                                   slot_free,
   output logic [ecpl_pkg::StatusWidth-1:0]       rsp_scan_status,
   output logic [ecpl_pkg::IndexWidth-1:0]        rsp_open_position,
   output logic [ecpl_pkg::IndexWidth-1:0]        rsp_close_position,
   output logic [ecpl_pkg::LengthWidth-1:0]       rsp_rewritten_length
);

   logic                                valid_ff, valid_in;
   logic [ecpl_pkg::StatusWidth-1:0]    status_ff, status_in;
   logic [ecpl_pkg::IndexWidth-1:0]     open_ff, open_in;
   logic [ecpl_pkg::IndexWidth-1:0]     close_ff, close_in;
   logic [ecpl_pkg::LengthWidth-1:0]    length_ff, length_in;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      open_in   = '0;
      close_in  = '0;
      length_in = '0;
      if (final_state.err_long) begin
         status_in = ecpl_pkg::StatusTooLong;
      end else if (final_state.err_depth) begin
         status_in = ecpl_pkg::StatusDepth;
      end else if (!final_state.in_parens) begin
         status_in = ecpl_pkg::StatusNoParen;
      end else if (!final_state.finished) begin
         status_in = ecpl_pkg::StatusUnbalanced;
      end else if (!final_state.only_ws) begin
         status_in = ecpl_pkg::StatusNotEmpty;
      end else begin
         status_in = ecpl_pkg::StatusOk;
         open_in   = final_state.open_index;
         close_in  = final_state.close_index;
         // length - (close - open + 1) + wrap + argument
         length_in = ecpl_pkg::LengthWidth'(final_state.position)
                   - ecpl_pkg::LengthWidth'(final_state.close_index)
                   + ecpl_pkg::LengthWidth'(final_state.open_index)
                   + ecpl_pkg::LengthWidth'(ecpl_pkg::WrapBytes - 1)
                   + ecpl_pkg::LengthWidth'(arg_length);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) valid_in = 1'b1;
      else if (rsp_ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status_in;
         open_ff   <= open_in;
         close_ff  <= close_in;
         length_ff <= length_in;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_scan_status      = status_ff;
   assign rsp_open_position    = open_ff;
   assign rsp_close_position   = close_ff;
   assign rsp_rewritten_length = length_ff;

endmodule

### sv/empty_call_paren_locator.sv
// ----------------------------------------------------------------------------
// empty_call_paren_locator
// finds the first call paren pair of a script and checks that it is empty
// ----------------------------------------------------------------------------
// script bytes stream in one beat per byte, the last one marked; the block
// takes a byte every cycle except while a final byte is stalled. each
// byte sits in an input register, then one lexer step updates the
// scan state (mode, depth, position, paren indices, flags). the final byte
// of a script yields one result beat through the result register: status,
// paren positions and the rewritten length with an argument of
// csr_write_data bytes quoted in parens. the result register lets the next
// script stream in while a result waits; a final byte only waits in the
// input register when an earlier result is still untaken. csr writes take
// effect at once and are meant for idle periods only.
module empty_call_paren_locator (
   input  logic                                   clock,
   input  logic                                   reset,
   // script byte beats
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [ecpl_pkg::ByteWidth-1:0]         req_script_byte,
   input  logic                                   req_last_byte,
   // result beats
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [ecpl_pkg::StatusWidth-1:0]       rsp_scan_status,
   output logic [ecpl_pkg::IndexWidth-1:0]        rsp_open_position,
   output logic [ecpl_pkg::IndexWidth-1:0]        rsp_close_position,
   output logic [ecpl_pkg::LengthWidth-1:0]       rsp_rewritten_length,
   // argument length register
   input  logic                                   csr_write_enable,
   input  logic [ecpl_pkg::IndexWidth-1:0]        csr_write_data
);

   // input register
   logic                                in_valid_ff, in_valid_in;
   logic [ecpl_pkg::ByteWidth-1:0]      in_byte_ff;
   logic                                in_last_ff;

   // scan state and argument length
   ecpl_pkg::scan_state_type            state_ff, state_in;
   ecpl_pkg::scan_state_type            lexed;
   logic [ecpl_pkg::IndexWidth-1:0]     arg_length_ff, arg_length_in;

   logic                                slot_free;
   logic                                advance;

   // a final byte needs room in the result register, any other byte goes on
   assign advance   = in_valid_ff && (!in_last_ff || slot_free);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) in_valid_in = req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_script_byte;
         in_last_ff <= req_last_byte;
      end
   end

   ecpl_lexer u_lexer (
      .cur_state   (state_ff),
      .script_byte (in_byte_ff),
      .next_state  (lexed)
   );

   // state clears after the final byte of each script
   always_comb begin
      state_in = state_ff;
      if (advance) begin
         if (in_last_ff) state_in = ecpl_pkg::ScanReset;
         else state_in = lexed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ecpl_pkg::ScanReset;
      end else begin
         state_ff <= state_in;
      end
   end

   assign arg_length_in = csr_write_enable ? csr_write_data : arg_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         arg_length_ff <= '0;
      end else begin
         arg_length_ff <= arg_length_in;
      end
   end

   ecpl_result u_result (
      .clock                (clock),
      .reset                (reset),
      .load                 (advance && in_last_ff),
      .final_state          (lexed),
      .arg_length           (arg_length_ff),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .slot_free            (slot_free),
      .rsp_scan_status      (rsp_scan_status),
      .rsp_open_position    (rsp_open_position),
      .rsp_close_position   (rsp_close_position),
      .rsp_rewritten_length (rsp_rewritten_length)
   );

endmodule

### dv/call_span_checker.sv
// ----------------------------------------------------------------------------
// call_span_checker
// predicts the call paren span of each script and checks every result beat
// ----------------------------------------------------------------------------
// watches the script byte, result and csr ports, keeps its own copy of the
// scan state and the argument length, queues one expected result per final
// byte and compares result beats against it in order
module call_span_checker
   import ecpl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [ByteWidth-1:0]   req_script_byte,
   input  logic                   req_last_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [StatusWidth-1:0] rsp_scan_status,
   input  logic [IndexWidth-1:0]  rsp_open_position,
   input  logic [IndexWidth-1:0]  rsp_close_position,
   input  logic [LengthWidth-1:0] rsp_rewritten_length,
   input  logic                   csr_write_enable,
   input  logic [IndexWidth-1:0]  csr_write_data,
   output int                     mismatches,
   output int                     pending,
   output int                     results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [IndexWidth-1:0]  open_pos;
      logic [IndexWidth-1:0]  close_pos;
      logic [LengthWidth-1:0] new_len;
   } call_result_type;

   logic [2:0]            lex_mode;
   logic                  in_call;
   int unsigned           depth;
   int unsigned           position;
   logic [IndexWidth-1:0] open_at;
   logic [IndexWidth-1:0] close_at;
   logic                  blank_only;
   logic                  matched;
   logic                  too_long;
   logic                  too_deep;
   logic [IndexWidth-1:0] arg_len;
   call_result_type       expected_calls[$];
   int                    errors = 0;
   int                    seen = 0;

   function automatic void clear_scan();
      lex_mode   = ModeNormal;
      in_call    = 1'b0;
      depth      = 0;
      position   = 0;
      open_at    = '0;
      close_at   = '0;
      blank_only = 1'b1;
      matched    = 1'b0;
      too_long   = 1'b0;
      too_deep   = 1'b0;
   endfunction

   // a byte seen in normal mode, or re-scanned after a lookahead fell through
   function automatic void take_fresh(logic [ByteWidth-1:0] b, int unsigned idx);
      if (b == ByteQuote) begin
         lex_mode = ModeStr;
      end else if (b == ByteLead) begin
         lex_mode = ModePendC2;
      end else if (b == ByteSlash) begin
         lex_mode = ModePendSlash;
      end else if (b == ByteOpen) begin
         if (!in_call) begin
            in_call    = 1'b1;
            open_at    = IndexWidth'(idx);
            depth      = 1;
            blank_only = 1'b1;
         end else if (depth >= MaxNestDepth) begin
            too_deep = 1'b1;
         end else begin
            depth++;
         end
      end else if (b == ByteClose && in_call) begin
         if (depth > 0) depth--;
         if (depth == 0) begin
            close_at = IndexWidth'(idx);
            matched  = 1'b1;
         end
      end
   endfunction

   function automatic void lex_byte(logic [ByteWidth-1:0] b, int unsigned idx);
      case (lex_mode)
         ModePendSlash: begin
            if (b == ByteSlash) lex_mode = ModeLine;
            else begin
               lex_mode = ModeNormal;
               take_fresh(b, idx);
            end
         end
         ModePendC2: begin
            if (b == ByteGuilOpen) lex_mode = ModeAngle;
            else begin
               lex_mode = ModeNormal;
               take_fresh(b, idx);
            end
         end
         ModeStr: begin
            if (b == ByteBackslash) lex_mode = ModeStrEsc;
            else if (b == ByteQuote) lex_mode = ModeNormal;
         end
         ModeStrEsc: lex_mode = ModeStr;
         ModeAngle: begin
            if (b == ByteLead) lex_mode = ModeAngleC2;
         end
         ModeAngleC2: begin
            if (b == ByteGuilClose) lex_mode = ModeNormal;
            else if (b != ByteLead) lex_mode = ModeAngle;
         end
         ModeLine: begin
            if (b == ByteLf || b == ByteCr) lex_mode = ModeNormal;
         end
         default: begin
            lex_mode = ModeNormal;
            take_fresh(b, idx);
         end
      endcase
   endfunction

   function automatic void take_byte(logic [ByteWidth-1:0] b, logic last);
      call_result_type r;
      logic            was_inside;
      if (position >= MaxScriptLen) begin
         too_long = 1'b1;
      end else begin
         if (!too_long && !too_deep && !matched) begin
            was_inside = in_call;
            lex_byte(b, position);
            if (was_inside && !matched &&
                !(b == ByteSpace || b == ByteTab || b == ByteCr || b == ByteLf))
               blank_only = 1'b0;
         end
         position++;
      end
      if (last) begin
         r = '0;
         if (too_long) r.status = StatusTooLong;
         else if (too_deep) r.status = StatusDepth;
         else if (!in_call) r.status = StatusNoParen;
         else if (!matched) r.status = StatusUnbalanced;
         else if (!blank_only) r.status = StatusNotEmpty;
         else begin
            r.status    = StatusOk;
            r.open_pos  = open_at;
            r.close_pos = close_at;
            r.new_len   = LengthWidth'(position + WrapBytes + arg_len
                                       - (close_at - open_at) - 1);
         end
         expected_calls.push_back(r);
         clear_scan();
      end
   endfunction

   function automatic void compare_field(string field, logic [31:0] want,
                                         logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : watch
      call_result_type want;
      if (reset) begin
         clear_scan();
         arg_len = '0;
         expected_calls.delete();
      end else begin
         if (csr_write_enable) arg_len = csr_write_data;
         if (req_valid && req_ready) take_byte(req_script_byte, req_last_byte);
         if (rsp_valid && rsp_ready) begin
            seen++;
            if (expected_calls.size() == 0) begin
               $error("scan_status: expected no result beat, got %0d", rsp_scan_status);
               errors++;
            end else begin
               want = expected_calls.pop_front();
               compare_field("scan_status", 32'(want.status), 32'(rsp_scan_status));
               compare_field("open_position", 32'(want.open_pos),
                             32'(rsp_open_position));
               compare_field("close_position", 32'(want.close_pos),
                             32'(rsp_close_position));
               compare_field("rewritten_length", 32'(want.new_len),
                             32'(rsp_rewritten_length));
            end
         end
      end
      mismatches   <= errors;
      pending      <= expected_calls.size();
      results_seen <= seen;
   end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the empty-call paren locator
// ----------------------------------------------------------------------------
// streams scripts into the locator one byte per beat: a directed set that
// hits every status short of too long, each lexer construct and the depth
// limit, then random scripts, mostly well-formed calls with random tokens
// around and inside them, the rest noise and damaged calls. three phases
// change the argument length and the idle mix of both channels. a checker
// beside the block predicts and compares every result beat
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ecpl_pkg::*;

   typedef logic [ByteWidth-1:0] script_type[$];

   // bytes per random phase
   localparam int PhaseBytes = 180;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [ByteWidth-1:0]   req_script_byte = '0;
   logic                   req_last_byte = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [StatusWidth-1:0] rsp_scan_status;
   logic [IndexWidth-1:0]  rsp_open_position;
   logic [IndexWidth-1:0]  rsp_close_position;
   logic [LengthWidth-1:0] rsp_rewritten_length;
   logic                   csr_write_enable = 1'b0;
   logic [IndexWidth-1:0]  csr_write_data = '0;

   int mismatches;
   int pending;
   int results_seen;

   // idle chances in percent, changed per phase
   int send_idle_pct = 19;
   int recv_idle_pct = 48;
   int bytes_sent = 0;
   int scripts_sent = 0;
   logic [IndexWidth-1:0] mid_arg_len;

   // script under construction
   script_type draft;

   empty_call_paren_locator u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_script_byte      (req_script_byte),
      .req_last_byte        (req_last_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_scan_status      (rsp_scan_status),
      .rsp_open_position    (rsp_open_position),
      .rsp_close_position   (rsp_close_position),
      .rsp_rewritten_length (rsp_rewritten_length),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   call_span_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_script_byte      (req_script_byte),
      .req_last_byte        (req_last_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_scan_status      (rsp_scan_status),
      .rsp_open_position    (rsp_open_position),
      .rsp_close_position   (rsp_close_position),
      .rsp_rewritten_length (rsp_rewritten_length),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .mismatches           (mismatches),
      .pending              (pending),
      .results_seen         (results_seen)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result side back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------------
   // script building
   // ---------------------------------------------------------------------

   function automatic void put_byte(logic [ByteWidth-1:0] b);
      draft.push_back(b);
   endfunction

   function automatic void put(string t);
      for (int i = 0; i < t.len(); i++) draft.push_back(t[i]);
   endfunction

   // one of the four bytes that still count as an empty call
   function automatic void put_blank();
      case ($urandom_range(3))
         0: put_byte(ByteSpace);
         1: put_byte(ByteTab);
         2: put_byte(ByteCr);
         default: put_byte(ByteLf);
      endcase
   endfunction

   // one lexer construct with random content; parens hidden inside strings
   // and comments must not be counted, terminators are sometimes left off
   function automatic void put_token();
      case ($urandom_range(7))
         0: repeat ($urandom_range(1, 5)) put_byte(8'(8'h61 + $urandom_range(25)));
         1: put_blank();
         2: begin
            put_byte(ByteQuote);
            repeat ($urandom_range(0, 4)) begin
               case ($urandom_range(3))
                  0: put_byte(ByteOpen);
                  1: put_byte(ByteClose);
                  2: begin
                     // escape, the next byte may well be a quote
                     put_byte(ByteBackslash);
                     put_byte($urandom_range(1) ? ByteQuote : 8'($urandom_range(255)));
                  end
                  default: put("a");
               endcase
            end
            if ($urandom_range(9) < 8) put_byte(ByteQuote);
         end
         3: begin
            put_byte(ByteLead);
            put_byte(ByteGuilOpen);
            repeat ($urandom_range(0, 4)) begin
               case ($urandom_range(3))
                  0: put_byte(ByteOpen);
                  1: put_byte(ByteClose);
                  2: put_byte(ByteLead);
                  default: put("x");
               endcase
            end
            if ($urandom_range(9) < 8) begin
               put_byte(ByteLead);
               put_byte(ByteGuilClose);
            end
         end
         4: begin
            put("//");
            repeat ($urandom_range(0, 3)) put_byte($urandom_range(1) ? ByteOpen : 8'h71);
            if ($urandom_range(9) < 8) put_byte($urandom_range(1) ? ByteCr : ByteLf);
         end
         5: begin
            // lone slash, its follower is scanned afresh
            put_byte(ByteSlash);
            put_byte($urandom_range(1) ? ByteOpen : 8'h62);
         end
         6: begin
            // lone lead byte without its guillemet partner
            put_byte(ByteLead);
            put_byte(8'($urandom_range(255)));
         end
         default: put_byte(8'($urandom_range(255)));
      endcase
   endfunction

   // mostly call-shaped scripts; one in ten is noise, some are damaged
   function automatic void put_random_script();
      int shape;
      shape = $urandom_range(9);
      if (shape == 0) begin
         repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(0, 3)) put_token();
         put_byte(ByteOpen);
         case ($urandom_range(4))
            0, 1, 2: repeat ($urandom_range(0, 3)) put_blank();
            3: put_token();
            default: begin
               put_byte(ByteOpen);
               if ($urandom_range(1)) put_blank();
               put_byte(ByteClose);
            end
         endcase
         put_byte(ByteClose);
         repeat ($urandom_range(0, 3)) put_token();
         // damage: drop one byte or slip a random one in
         if (shape == 1 && draft.size() > 1) draft.delete($urandom_range(draft.size() - 1));
         if (shape == 2) draft.insert($urandom_range(draft.size()), 8'($urandom_range(255)));
      end
   endfunction

   // ---------------------------------------------------------------------
   // channel driving
   // ---------------------------------------------------------------------

   // one byte beat; valid stays up with the same payload until taken
   task automatic send_byte(input logic [ByteWidth-1:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_script_byte <= b;
      req_last_byte   <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_draft();
      foreach (draft[i]) send_byte(draft[i], i == draft.size() - 1);
      draft.delete();
      scripts_sent++;
   endtask

   // let every queued result come back, then allow for the pipeline
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_arg_length(input logic [IndexWidth-1:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_random(input int count);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < count) begin
         put_random_script();
         send_draft();
      end
   endtask

   // ---------------------------------------------------------------------
   // directed scripts
   // ---------------------------------------------------------------------

   task automatic run_directed();
      // plain empty call
      put("f()");
      send_draft();
      // every blank byte inside, trailing text only counted
      put("go(");
      put_byte(ByteSpace);
      put_byte(ByteTab);
      put_byte(ByteCr);
      put_byte(ByteLf);
      put(")x");
      send_draft();
      // no paren at all
      put("abc");
      send_draft();
      // never closed
      put("f(");
      send_draft();
      // argument present
      put("f(a)");
      send_draft();
      // paren hidden in a string with an escaped quote
      put_byte(ByteQuote);
      put("(");
      put_byte(ByteBackslash);
      put_byte(ByteQuote);
      put(")");
      put_byte(ByteQuote);
      put("()");
      send_draft();
      // guillemet comment with a doubled lead byte before its close
      put_byte(ByteLead);
      put_byte(ByteGuilOpen);
      put("(");
      put_byte(ByteLead);
      put_byte(ByteLead);
      put_byte(ByteGuilClose);
      put("()");
      send_draft();
      // line comments ended by lf and by cr
      put("//(");
      put_byte(ByteLf);
      put("a()");
      send_draft();
      put("//)");
      put_byte(ByteCr);
      put("()");
      send_draft();
      // lookahead that falls through: slash or lead then a real paren
      put("/()");
      send_draft();
      put_byte(ByteLead);
      put("()");
      send_draft();
      // lookahead pending when the script ends
      put("f(/");
      send_draft();
      put_byte(ByteLead);
      send_draft();
      // unterminated string and unterminated comment
      put_byte(ByteQuote);
      put("(");
      send_draft();
      put("(");
      put_byte(ByteLead);
      put_byte(ByteGuilOpen);
      put(")");
      send_draft();
      // nested parens, a string and a comment all make the call non-empty
      put("f(())");
      send_draft();
      put("f( ");
      put_byte(ByteQuote);
      put_byte(ByteQuote);
      put(" )");
      send_draft();
      put("( //");
      put_byte(ByteLf);
      put(")");
      send_draft();
      // bytes after the match are only counted
      put("f())(");
      put_byte(8'hFF);
      send_draft();
      // lowest and highest byte values, and a stray close
      put_byte(8'h00);
      put_byte(8'hFF);
      send_draft();
      put(")");
      send_draft();
      // one nesting level too many
      repeat (MaxNestDepth + 1) put("(");
      send_draft();
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // phase one: sender idles lightly, receiver heavily, widest argument
      write_arg_length(16'hFFFF);
      run_directed();
      drain();
      run_random(PhaseBytes);
      drain();

      // phase two: the idle mix swapped, a random argument length
      mid_arg_len = 16'($urandom_range(1, 65534));
      write_arg_length(mid_arg_len);
      send_idle_pct = 48;
      recv_idle_pct = 19;
      run_random(PhaseBytes);
      drain();

      // phase three: full rate on both sides, empty argument
      write_arg_length(16'h0000);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(PhaseBytes);
      drain();

      $display("summary: %0d scripts in %0d byte beats, %0d result beats compared",
               scripts_sent, bytes_sent, results_seen);
      $display("summary: argument lengths 65535, %0d and 0 over three idle mixes",
               mid_arg_len);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // watchdog, far beyond the length of a correct run
   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
